// ===== hdl/tkbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Top-k box table package
// Shared types, table size, status and action codes, and the extent helper.
// ----------------------------------------------------------------------------
package tkbt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef logic [IDX_W-1:0] t_idx;
    localparam t_idx LAST_IDX = t_idx'(TABLE_ENTRIES - 1);

    typedef logic [15:0] t_q16;

    // x_low sits in the low bits, y_high in the high bits
    typedef struct packed {
        t_q16 y_high;
        t_q16 x_high;
        t_q16 y_low;
        t_q16 x_low;
    } t_box;

    typedef struct packed {
        t_box box;
        t_q16 score;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic re;
        t_idx raddr;
        logic we;
        t_idx waddr;
    } t_store_req;

    typedef logic [2:0] t_status;
    localparam t_status STATUS_DONE       = 3'd0;
    localparam t_status STATUS_INSERTED   = 3'd1;
    localparam t_status STATUS_UNDER      = 3'd2;
    localparam t_status STATUS_BELOW_LAST = 3'd3;
    localparam t_status STATUS_SUPPRESSED = 3'd4;

    typedef logic [1:0] t_action;
    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_INSERT = 2'd1;
    localparam t_action ACT_READ   = 2'd2;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Span from lo to hi, zero when inverted
    function automatic t_q16 extent(input t_q16 lo, input t_q16 hi);
        extent = (hi > lo) ? t_q16'(hi - lo) : '0;
    endfunction

endpackage

// ===== hdl/tkbt_store.sv =====
// ----------------------------------------------------------------------------
// Top-k box table store
// One write port, one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
module tkbt_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tkbt_pkg::t_store_req i_req,
    input  tkbt_pkg::t_entry    i_wdata,
    output tkbt_pkg::t_entry    o_rdata
);
    import tkbt_pkg::*;

    t_entry                   r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                   r_rdata;
    logic                     r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    // Invalid entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.we) begin
                r_valid[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvalid <= r_valid[i_req.raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== hdl/tkbt_mul.sv =====
// ----------------------------------------------------------------------------
// Top-k box table shared multiplier
// One 32x16 unsigned product per cycle, registered.
// ----------------------------------------------------------------------------
module tkbt_mul (
    input  logic                          i_clk,
    input  logic [tkbt_pkg::MUL_A_W-1:0]  i_a,
    input  logic [tkbt_pkg::MUL_B_W-1:0]  i_b,
    output logic [tkbt_pkg::PROD_W-1:0]   o_p
);
    import tkbt_pkg::*;

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== hdl/topk_box_table_with_overlap_suppression_core.sv =====
// ----------------------------------------------------------------------------
// Top-k detection box table with overlap suppression
// Sorted score table, overlap test by cross-multiplication, one shared
// multiplier stepped by a small sequencer.
// ----------------------------------------------------------------------------
// The block keeps up to TABLE_ENTRIES boxes sorted by descending score and
// answers one result item per input item. Clear, read and an insert under
// threshold go straight to the result; any other insert first reads the last
// entry, and one that scores below it ends there. A full insert then forms
// the suppress limit and scans the occupied entries from the top (up to and
// including the overlap hit, or all TABLE_ENTRIES); an empty slot ends the
// scan after its table read. It then shifts lower-scored entries down and
// writes the new one; a suppressed insert stops at the hit. Each scanned
// entry needs one table read and one pass through the shared multiplier,
// each shifted entry one registered read and then one write. Input stall
// stays high while an item is in work; a finished result sits in the output
// register, so the next item is taken while that result waits.
// The user must write configuration over the APB port only while the block
// is idle; the block itself does not enforce it. pready is always high.
// ----------------------------------------------------------------------------
module topk_box_table_with_overlap_suppression_core (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_x_low,
    input  logic [15:0] i_y_low,
    input  logic [15:0] i_x_high,
    input  logic [15:0] i_y_high,
    input  logic [15:0] i_confidence,
    input  logic [3:0]  i_entry_index,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_read_x_low,
    output logic [15:0] o_read_y_low,
    output logic [15:0] o_read_x_high,
    output logic [15:0] o_read_y_high,
    output logic [15:0] o_read_score,
    output logic [15:0] o_offered_count,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tkbt_pkg::*;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_FRACTION  = 1'b1;
    localparam t_q16 CFG_RESET     = 16'h8000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST_RD,
        S_AREA,
        S_FRAC,
        S_SCAN_MUL,
        S_SCAN_CMP,
        S_SHIFT_CHK,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_AREA,
        MUL_FRAC,
        MUL_INTER
    } t_mul_sel;

    // Control registers
    t_state  r_state,   n_state;
    t_q16    r_thr,     n_thr;
    t_q16    r_frac,    n_frac;
    t_q16    r_offered, n_offered;
    logic    r_out_valid, n_out_valid;

    // Work and result registers
    t_box              r_box,       n_box;
    t_q16              r_conf,      n_conf;
    t_idx              r_pos,       n_pos;
    t_q16              r_cur_score, n_cur_score;
    logic [PROD_W-1:0] r_limit,     n_limit;
    t_status           r_res_status, n_res_status;
    logic              r_res_rd,    n_res_rd;
    t_status           r_out_status, n_out_status;
    t_entry            r_out_entry, n_out_entry;
    t_q16              r_out_count, n_out_count;

    t_store_req         s_req;
    t_entry             s_wdata;
    t_entry             s_rd;
    t_mul_sel           s_mul_sel;
    logic [MUL_A_W-1:0] s_mul_a;
    logic [MUL_B_W-1:0] s_mul_b;
    logic [PROD_W-1:0]  s_mul_p;
    logic               s_in_acc;
    logic               s_out_free;
    logic               s_hit;
    t_q16               s_ix_lo, s_ix_hi, s_iy_lo, s_iy_hi;

    tkbt_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .i_wdata (s_wdata),
        .o_rdata (s_rd)
    );

    tkbt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (s_mul_a),
        .i_b   (s_mul_b),
        .o_p   (s_mul_p)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign s_in_acc   = i_in_valid && !o_in_stall;
    assign s_out_free = !r_out_valid || !i_out_stall;

    // Intersection corners of the new box against the entry just read
    assign s_ix_lo = (r_box.x_low  > s_rd.box.x_low)  ? r_box.x_low  : s_rd.box.x_low;
    assign s_ix_hi = (r_box.x_high < s_rd.box.x_high) ? r_box.x_high : s_rd.box.x_high;
    assign s_iy_lo = (r_box.y_low  > s_rd.box.y_low)  ? r_box.y_low  : s_rd.box.y_low;
    assign s_iy_hi = (r_box.y_high < s_rd.box.y_high) ? r_box.y_high : s_rd.box.y_high;

    // Shared multiplier operands: box area, fraction times area, intersection
    always_comb begin
        case (s_mul_sel)
            MUL_AREA: begin
                s_mul_a = MUL_A_W'(extent(r_box.x_low, r_box.x_high));
                s_mul_b = extent(r_box.y_low, r_box.y_high);
            end
            MUL_FRAC: begin
                s_mul_a = s_mul_p[MUL_A_W-1:0];
                s_mul_b = r_frac;
            end
            default: begin
                s_mul_a = MUL_A_W'(extent(s_ix_lo, s_ix_hi));
                s_mul_b = extent(s_iy_lo, s_iy_hi);
            end
        endcase
    end

    // Suppress when intersection * 2^16 exceeds fraction * area
    assign s_hit = {s_mul_p[31:0], 16'h0000} > r_limit;

    assign prdata = {16'h0000, (paddr[2] == REG_FRACTION) ? r_frac : r_thr};
    assign pready = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_thr        = r_thr;
        n_frac       = r_frac;
        n_offered    = r_offered;
        n_box        = r_box;
        n_conf       = r_conf;
        n_pos        = r_pos;
        n_cur_score  = r_cur_score;
        n_limit      = r_limit;
        n_res_status = r_res_status;
        n_res_rd     = r_res_rd;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && i_out_stall;
        s_req        = '0;
        s_wdata      = '0;
        s_mul_sel    = MUL_INTER;

        // Register writes
        if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_THRESHOLD: n_thr  = pwdata[15:0];
                REG_FRACTION:  n_frac = pwdata[15:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (s_in_acc) begin
                    n_box        = '{y_high: i_y_high, x_high: i_x_high,
                                    y_low: i_y_low, x_low: i_x_low};
                    n_conf       = i_confidence;
                    n_res_status = STATUS_DONE;
                    n_res_rd     = 1'b0;
                    n_state      = S_DONE;
                    case (i_action)
                        ACT_CLEAR: begin
                            s_req.clear = 1'b1;
                            n_offered   = '0;
                        end
                        ACT_INSERT: begin
                            if (i_confidence <= r_thr) begin
                                n_res_status = STATUS_UNDER;
                            end else begin
                                if (r_offered != '1) begin
                                    n_offered = r_offered + 16'd1;
                                end
                                // fetch the last entry for the drop test
                                s_req.re    = 1'b1;
                                s_req.raddr = LAST_IDX;
                                n_state     = S_LAST_RD;
                            end
                        end
                        ACT_READ: begin
                            if (32'(i_entry_index) < TABLE_ENTRIES) begin
                                s_req.re    = 1'b1;
                                s_req.raddr = t_idx'(i_entry_index);
                                n_res_rd    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LAST_RD: begin
                if (r_conf < s_rd.score) begin
                    n_res_status = STATUS_BELOW_LAST;
                    n_state      = S_DONE;
                end else begin
                    s_mul_sel = MUL_AREA;
                    n_state   = S_AREA;
                end
            end
            S_AREA: begin
                s_mul_sel = MUL_FRAC;
                n_state   = S_FRAC;
            end
            S_FRAC: begin
                // hold the suppress limit, start the scan at the top entry
                n_limit     = s_mul_p;
                s_req.re    = 1'b1;
                s_req.raddr = '0;
                n_pos       = '0;
                n_state     = S_SCAN_MUL;
            end
            S_SCAN_MUL: begin
                n_cur_score = s_rd.score;
                if (s_rd.score < r_thr) begin
                    // empty slot ends the scan
                    n_state = S_SHIFT_CHK;
                end else begin
                    s_mul_sel = MUL_INTER;
                    n_state   = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (s_hit) begin
                    if (r_cur_score >= r_conf) begin
                        n_res_status = STATUS_SUPPRESSED;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_SHIFT_CHK;
                    end
                end else if (r_pos == LAST_IDX) begin
                    n_state = S_SHIFT_CHK;
                end else begin
                    n_pos       = r_pos + t_idx'(1);
                    s_req.re    = 1'b1;
                    s_req.raddr = r_pos + t_idx'(1);
                    n_state     = S_SCAN_MUL;
                end
            end
            S_SHIFT_CHK: begin
                // r_cur_score is the original score at r_pos
                if ((r_pos != '0) && (r_cur_score < r_conf)) begin
                    s_req.re    = 1'b1;
                    s_req.raddr = r_pos - t_idx'(1);
                    n_state     = S_SHIFT;
                end else begin
                    s_req.we      = 1'b1;
                    s_req.waddr   = r_pos;
                    s_wdata.box   = r_box;
                    s_wdata.score = r_conf;
                    n_res_status  = STATUS_INSERTED;
                    n_state       = S_DONE;
                end
            end
            S_SHIFT: begin
                // move the entry above down one slot
                s_req.we    = 1'b1;
                s_req.waddr = r_pos;
                s_wdata     = s_rd;
                n_pos       = r_pos - t_idx'(1);
                n_cur_score = s_rd.score;
                n_state     = S_SHIFT_CHK;
            end
            S_DONE: begin
                if (s_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_rd ? s_rd : '0;
                    n_out_count  = r_offered;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_box        <= n_box;
        r_conf       <= n_conf;
        r_pos        <= n_pos;
        r_cur_score  <= n_cur_score;
        r_limit      <= n_limit;
        r_res_status <= n_res_status;
        r_res_rd     <= n_res_rd;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_count  <= n_out_count;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= CFG_RESET;
            r_frac      <= CFG_RESET;
            r_offered   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_thr       <= n_thr;
            r_frac      <= n_frac;
            r_offered   <= n_offered;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_read_x_low    = r_out_entry.box.x_low;
    assign o_read_y_low    = r_out_entry.box.y_low;
    assign o_read_x_high   = r_out_entry.box.x_high;
    assign o_read_y_high   = r_out_entry.box.y_high;
    assign o_read_score    = r_out_entry.score;
    assign o_offered_count = r_out_count;

endmodule

// ===== hdl/tkbt_checker.sv =====
// ----------------------------------------------------------------------------
// Top-k box table port checker
// Watches the top-level ports and flags result items that break the rules.
// ----------------------------------------------------------------------------
module tkbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_read_x_low,
    input logic [15:0] o_read_y_low,
    input logic [15:0] o_read_x_high,
    input logic [15:0] o_read_y_high,
    input logic [15:0] o_read_score,
    input logic [15:0] o_offered_count
);
    import tkbt_pkg::*;

    // The block is busy in the cycle after it accepts an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_read_score)
             && $stable(o_read_x_low) && $stable(o_offered_count)))
        else $error("stalled result item changed");

    // Status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= STATUS_SUPPRESSED))
        else $error("undefined status code");

    // Only a read carries entry fields
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STATUS_DONE)) |->
            ((o_read_x_low == '0) && (o_read_y_low == '0) && (o_read_x_high == '0)
             && (o_read_y_high == '0) && (o_read_score == '0)))
        else $error("entry fields set on a non-read result");

endmodule

bind topk_box_table_with_overlap_suppression_core tkbt_checker u_tkbt_checker (.*);
